// ===== rtl/core/uds_pkg.sv =====
`timescale 1ns / 1ps

package uds_pkg;

  localparam int unsigned FRAC_W    = 32;   // width of one random fraction
  localparam int unsigned RADIUS_W  = 31;   // disk radius, unsigned Q15.16
  localparam int unsigned COORD_W   = 32;   // output coordinate, signed Q15.16
  localparam int unsigned REM_W     = 34;   // square root partial remainder
  localparam int unsigned XY_W      = 42;   // CORDIC x/y, 24 fractional bits
  localparam int unsigned Z_W       = 63;   // CORDIC angle, Q2.60
  localparam int unsigned GUARD_SHIFT = 8;  // 24 guard fraction bits down to 16

  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic [31:0] PI_HI  = 32'h3243_F6A8;
  localparam logic [31:0] PI_LO  = 32'h885A_308D;

  localparam logic signed [33:0] COORD_MAX = 34'sd2147483647;
  localparam logic signed [33:0] COORD_MIN = -34'sd2147483647;

  // One beat inside the square root chain.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [FRAC_W-1:0] root;
    logic [FRAC_W-1:0] rad;
    logic [FRAC_W-1:0] ang;
  } sqrt_beat_t;

  // One beat inside the rotation chain.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
  } cordic_beat_t;

  // Integer square root, bit by bit; used at elaboration only.
  function automatic logic [63:0] uds_isqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    int          k;
    rem  = n;
    res  = '0;
    bitv = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Product of (1 + 2^-2i) over all stages, Q60.
  function automatic logic [63:0] uds_gain_prod(input int unsigned stages);
    logic [63:0] prod;
    int unsigned i;
    prod = 64'd1 << 60;
    for (i = 0; i < stages; i++) begin
      if (2 * i < 64) begin
        prod = prod + (prod >> (2 * i));
      end
    end
    return prod;
  endfunction

  // Shift-subtract quotient of two constants; used at elaboration only.
  function automatic logic [63:0] uds_quot(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q2.60: pi/4 for i = 0, else from the truncated power series.
  function automatic logic signed [Z_W-1:0] uds_atan(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        k;
    int unsigned        e;
    sum = '0;
    if (i == 0) begin
      sum = $signed(PI_Q60 >> 2);
    end else begin
      for (k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = uds_quot(64'd1 << (60 - e), 64'(2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - $signed(term);
          end else begin
            sum = sum + $signed(term);
          end
        end
      end
    end
    return Z_W'(sum);
  endfunction

endpackage

// ===== rtl/core/uniform_disk_point_sampler_unit.sv =====
`timescale 1ns / 1ps
// Pipeline from input beat to output beat:
//   32 square root cells, 2 scaling stages, one CORDIC cell per stage, 1 output register.
// Throughput: one beat per cycle unless stalled; all cells advance on one shared enable.
// Reset (rst_ni low, asynchronous): valid bits cleared, disk radius cleared to 0;
//   the block accepts beats in the first cycle after reset.

module uniform_disk_point_sampler_unit import uds_pkg::*; #(
  parameter int unsigned RAND_BITS     = 32,
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: disk_radius, unsigned Q15.16
  input  logic                cfg_we_i,
  input  logic [RADIUS_W-1:0] cfg_wdata_i,
  // input beats
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,  // [31:0] u_radius, [63:32] u_angle
  // output beats
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [63:0]         m_axis_tdata_o   // [31:0] point_x, [63:32] point_y
);

  // Only the top RAND_BITS bits of each fraction take part; lower bits read as zero.
  localparam int unsigned KEEP = (RAND_BITS < FRAC_W) ? RAND_BITS : FRAC_W;
  localparam logic [FRAC_W-1:0] KEEP_MASK = ~({FRAC_W{1'b1}} >> KEEP);

  logic [RADIUS_W-1:0] radius_q;

  // Shared advance: hold every cell only when a finished beat sits at the
  // chain end and the output register is still full.
  logic en;
  logic last_valid;

  sqrt_beat_t   sq_beat  [FRAC_W+1];
  logic         sq_valid [FRAC_W+1];
  cordic_beat_t cr_beat  [CORDIC_STAGES+1];
  logic         cr_valid [CORDIC_STAGES+1];

  logic                      out_valid_q, out_valid_d;
  logic [COORD_W-1:0]        out_x_q, out_y_q;
  logic [COORD_W-1:0]        sat_x, sat_y;
  logic signed [XY_W-1:0]    ox, oy;
  logic signed [33:0]        fx, fy;

  assign last_valid      = cr_valid[CORDIC_STAGES];
  assign en              = !out_valid_q || m_axis_tready_i || !last_valid;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Feed the first square root cell straight from the input beat.
  always_comb begin
    sq_valid[0]     = s_axis_tvalid_i;
    sq_beat[0].rem  = '0;
    sq_beat[0].root = '0;
    sq_beat[0].rad  = s_axis_tdata_i[FRAC_W-1:0] & KEEP_MASK;
    sq_beat[0].ang  = s_axis_tdata_i[2*FRAC_W-1:FRAC_W] & KEEP_MASK;
  end

  // Square root of u_radius * 2^32, one root bit per cell.
  for (genvar j = 0; j < FRAC_W; j++) begin : g_sqrt
    uds_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[j]),
      .beat_i  (sq_beat[j]),
      .valid_o (sq_valid[j+1]),
      .beat_o  (sq_beat[j+1])
    );
  end

  // Radius, gain pre-scale and angle in radians.
  uds_scale #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_valid[FRAC_W]),
    .beat_i   (sq_beat[FRAC_W]),
    .radius_i (radius_q),
    .valid_o  (cr_valid[0]),
    .beat_o   (cr_beat[0])
  );

  // Rotation inside the first quadrant, one CORDIC iteration per cell.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    uds_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cr_valid[i]),
      .beat_i  (cr_beat[i]),
      .valid_o (cr_valid[i+1]),
      .beat_o  (cr_beat[i+1])
    );
  end

  // Map back to the quadrant, floor to 16 fraction bits, saturate.
  always_comb begin
    unique case (cr_beat[CORDIC_STAGES].quad)
      2'd0: begin
        ox = cr_beat[CORDIC_STAGES].x;
        oy = cr_beat[CORDIC_STAGES].y;
      end
      2'd1: begin
        ox = -cr_beat[CORDIC_STAGES].y;
        oy = cr_beat[CORDIC_STAGES].x;
      end
      2'd2: begin
        ox = -cr_beat[CORDIC_STAGES].x;
        oy = -cr_beat[CORDIC_STAGES].y;
      end
      default: begin
        ox = cr_beat[CORDIC_STAGES].y;
        oy = -cr_beat[CORDIC_STAGES].x;
      end
    endcase
    fx = 34'(ox >>> GUARD_SHIFT);
    fy = 34'(oy >>> GUARD_SHIFT);
    if (fx > COORD_MAX) begin
      sat_x = COORD_W'(COORD_MAX);
    end else if (fx < COORD_MIN) begin
      sat_x = COORD_W'(COORD_MIN);
    end else begin
      sat_x = COORD_W'(fx);
    end
    if (fy > COORD_MAX) begin
      sat_y = COORD_W'(COORD_MAX);
    end else if (fy < COORD_MIN) begin
      sat_y = COORD_W'(COORD_MIN);
    end else begin
      sat_y = COORD_W'(fy);
    end
  end

  // Output register: drop the beat once taken, load a new one on advance.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (en && last_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_valid) begin
      out_x_q <= sat_x;
      out_y_q <= sat_y;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};

  // A full output register with a finished beat behind it must hold the chain.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && last_valid) |-> !s_axis_tready_o)
    else $error("chain advanced over a waiting result");

  // A beat leaving the chain lands in the output register.
  a_load_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && last_valid) |=> m_axis_tvalid_o)
    else $error("finished beat lost at the output register");

  // Saturation never yields the most negative code.
  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31:0] != 32'h8000_0000 &&
                         m_axis_tdata_o[63:32] != 32'h8000_0000))
    else $error("coordinate outside saturation range");

endmodule

// ===== rtl/core/uds_sqrt_cell.sv =====
`timescale 1ns / 1ps

module uds_sqrt_cell import uds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  sqrt_beat_t beat_i,
  output logic       valid_o,
  output sqrt_beat_t beat_o
);

  logic       valid_q;
  sqrt_beat_t beat_q, beat_d;
  logic [REM_W+1:0] cand;
  logic [REM_W+1:0] trial;

  // One root bit per cell: bring down two radicand bits, try the subtract.
  always_comb begin
    cand  = {beat_i.rem, beat_i.rad[FRAC_W-1 -: 2]};
    trial = {2'b00, beat_i.root, 2'b01};
    beat_d     = beat_i;
    beat_d.rad = {beat_i.rad[FRAC_W-3:0], 2'b00};
    if (cand >= trial) begin
      beat_d.rem  = REM_W'(cand - trial);
      beat_d.root = {beat_i.root[FRAC_W-2:0], 1'b1};
    end else begin
      beat_d.rem  = REM_W'(cand);
      beat_d.root = {beat_i.root[FRAC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/uds_scale.sv =====
`timescale 1ns / 1ps

module uds_scale import uds_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sqrt_beat_t          beat_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                valid_o,
  output cordic_beat_t        beat_o
);

  localparam logic [63:0] GAIN_PROD = uds_gain_prod(CORDIC_STAGES);
  localparam logic [63:0] GAIN_ROOT = uds_isqrt(GAIN_PROD);
  localparam logic [31:0] GAIN      = 32'((64'd1 << 62) / GAIN_ROOT);

  logic        a_valid_q, b_valid_q;
  logic [62:0] rprod_q;
  logic [61:0] ahi_q, alo_q;
  logic [1:0]  a_quad_q, b_quad_q;
  logic [62:0] gprod_q, gprod_d;
  logic [Z_W-1:0] z_q, z_d;
  logic [RADIUS_W-1:0] r;

  // Stage B: radius from the square root product, then pre-scale by the gain.
  assign r       = rprod_q[62:32];
  assign gprod_d = 63'(r) * 63'(GAIN);
  assign z_d     = {ahi_q, 1'b0} + 63'(alo_q >> 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rprod_q  <= 63'(radius_i) * 63'(beat_i.root);
      ahi_q    <= 62'(beat_i.ang[29:0]) * 62'(PI_HI);
      alo_q    <= 62'(beat_i.ang[29:0]) * 62'(PI_LO);
      a_quad_q <= beat_i.ang[FRAC_W-1 -: 2];
      gprod_q  <= gprod_d;
      z_q      <= z_d;
      b_quad_q <= a_quad_q;
    end
  end

  always_comb begin
    beat_o.x    = XY_W'(gprod_q >> 24);
    beat_o.y    = '0;
    beat_o.z    = $signed(z_q);
    beat_o.quad = b_quad_q;
  end

  assign valid_o = b_valid_q;

endmodule

// ===== rtl/core/uds_cordic_cell.sv =====
`timescale 1ns / 1ps

module uds_cordic_cell import uds_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  cordic_beat_t beat_i,
  output logic         valid_o,
  output cordic_beat_t beat_o
);

  localparam logic signed [Z_W-1:0] ATAN = uds_atan(IDX);

  logic         valid_q;
  cordic_beat_t beat_q, beat_d;
  logic signed [XY_W-1:0] xin, yin, dx, dy;
  logic signed [Z_W-1:0]  zin;

  // Fixed shift per cell; rotate toward zero residual angle.
  always_comb begin
    xin = beat_i.x;
    yin = beat_i.y;
    zin = beat_i.z;
    dx  = yin >>> IDX;
    dy  = xin >>> IDX;
    beat_d      = beat_i;
    if (!zin[Z_W-1]) begin
      beat_d.x = xin - dx;
      beat_d.y = yin + dy;
      beat_d.z = zin - ATAN;
    end else begin
      beat_d.x = xin + dx;
      beat_d.y = yin - dy;
      beat_d.z = zin + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== tb/disk_point_checker.sv =====
`timescale 1ns / 1ps

module disk_point_checker import uds_pkg::*; #(
  parameter int unsigned RAND_BITS     = 32,
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RADIUS_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [63:0]         in_data_i,    // [31:0] u_radius, [63:32] u_angle
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [63:0]         out_data_i,   // [31:0] point_x, [63:32] point_y
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  localparam int unsigned ROT_FRAC = 24;  // fraction bits inside the rotation

  longint              atan_q60 [CORDIC_STAGES];
  logic [63:0]         gain_q32;
  logic [RADIUS_W-1:0] radius_q16 = '0;
  point_t              expected_points [$];
  int                  fails = 0;
  int                  reported = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] probe;
    rest  = n;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Keep only the top RAND_BITS bits of a fraction.
  function automatic logic [31:0] trim_frac(input logic [31:0] u);
    if (RAND_BITS >= 32) return u;
    return u & ~((32'd1 << (32 - RAND_BITS)) - 32'd1);
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 32'sd2147483647;
    if (v < -64'sd2147483647) return -32'sd2147483647;
    return v[31:0];
  endfunction

  function automatic point_t predict_point(input logic [31:0] u_rad, input logic [31:0] u_ang,
                                           input logic [RADIUS_W-1:0] rad);
    logic [31:0] ur;
    logic [31:0] ua;
    logic [63:0] root;
    logic [63:0] r_q16;
    logic [63:0] a;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      ox;
    longint      oy;
    int unsigned i;
    point_t      p;
    ur    = trim_frac(u_rad);
    ua    = trim_frac(u_ang);
    root  = floor_sqrt({ur, 32'd0});
    r_q16 = (64'(rad) * root) >> 32;
    // angle inside the quadrant, in radians Q2.60
    a = 64'(ua[29:0]);
    z = longint'(((a * 64'(PI_HI)) << 1) + ((a * 64'(PI_LO)) >> 31));
    x = longint'((r_q16 * gain_q32) >> (64 - ROT_FRAC - 16));
    y = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q60[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q60[i];
      end
    end
    case (ua[31:30])
      2'd0: begin ox = x;  oy = y;  end
      2'd1: begin ox = -y; oy = x;  end
      2'd2: begin ox = -x; oy = -y; end
      default: begin ox = y; oy = -x; end
    endcase
    p.x = clamp_coord(ox >>> (ROT_FRAC - 16));
    p.y = clamp_coord(oy >>> (ROT_FRAC - 16));
    return p;
  endfunction

  // Arctangent table from the truncated series, and the inverse CORDIC gain.
  initial begin : build_tables
    logic [63:0] prod;
    logic [63:0] term;
    longint      acc;
    int unsigned i;
    int unsigned k;
    prod = 64'd1 << 60;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = longint'(PI_Q60 >> 2);
      end else begin
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
      end
      atan_q60[i] = acc;
      if (2 * i < 64) prod = prod + (prod >> (2 * i));
    end
    gain_q32 = (64'd1 << 62) / floor_sqrt(prod);
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t got;
    point_t want;
    if (!rst_ni) begin
      radius_q16 = '0;
      expected_points.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_points.push_back(predict_point(in_data_i[31:0], in_data_i[63:32], radius_q16));
      end
      if (cfg_we_i) radius_q16 = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        got.x = out_data_i[31:0];
        got.y = out_data_i[63:32];
        if (expected_points.size() == 0) begin
          fails++;
          if (reported < 10) begin
            $display("unexpected point beat: x=%0d y=%0d", got.x, got.y);
          end
          reported++;
        end else begin
          want = expected_points.pop_front();
          if (got.x != want.x || got.y != want.y) begin
            fails++;
            if (reported < 10) begin
              $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.x, want.y, got.x, got.y);
            end
            reported++;
          end
        end
      end
    end
    pending_o  <= expected_points.size();
    fail_cnt_o <= fails;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import uds_pkg::*;

  localparam int unsigned RAND_BITS       = 32;
  localparam int unsigned CORDIC_STAGES   = 24;
  localparam int unsigned PIPE_DEPTH      = 35 + CORDIC_STAGES;  // input beat to output beat
  localparam int unsigned PHASES          = 8;
  localparam int unsigned BEATS_PER_PHASE = 136;
  localparam int unsigned STALL_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [RADIUS_W-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [63:0]         s_axis_tdata_i  = '0;  // [31:0] u_radius, [63:32] u_angle
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [63:0]         m_axis_tdata_o;        // [31:0] point_x, [63:32] point_y

  int                  src_idle_pct    = 0;
  int                  rx_idle_pct     = 0;
  logic                stall_req       = 1'b0;
  int                  stall_left      = 0;
  int                  cycle_cnt       = 0;
  int                  fail_cnt;
  int                  pending;

  // Angles at and around every quadrant boundary.
  logic [31:0] corner_ang [8] = '{32'h0000_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'hBFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF};
  // Disk radius per random phase; odd phases from three on draw a fresh value.
  logic [RADIUS_W-1:0] phase_radius [PHASES] = '{31'h7FFF_FFFF, 31'h0001_0000, 31'h0000_0001,
                                                 31'h0, 31'h0, 31'h0, 31'h00A0_0000, 31'h0};

  uniform_disk_point_sampler_unit #(
    .RAND_BITS     (RAND_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predict and compare every point beat on the side.
  disk_point_checker #(
    .RAND_BITS     (RAND_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_point_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_i (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_i  (m_axis_tdata_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Guard against a hang: stop the run once the cycle budget is spent.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: drop tready at random, or hold it low for a long stretch on request
  // so that the pipeline fills up and pushes back on the input side.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (stall_req) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= STALL_CYCLES;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic set_idle(input int src_pct, input int rx_pct);
    src_idle_pct = src_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Offer one beat, with a random gap ahead of it; return right after acceptance
  // with tvalid still high so that beats can go back to back.
  task automatic send_fracs(input logic [31:0] u_rad, input logic [31:0] u_ang);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {u_ang, u_rad};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Drop tvalid and hold until every expected point has come out.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_radius(input logic [RADIUS_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Fraction with extra weight near zero, near one and near quadrant boundaries.
  function automatic logic [31:0] rand_frac();
    logic [31:0] quad_base;
    quad_base = {2'($urandom_range(3)), 30'd0};
    case ($urandom_range(7))
      0: return $urandom_range(255);
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      2: return quad_base + $urandom_range(31) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [RADIUS_W-1:0] rad;
    int unsigned         p;
    int unsigned         n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(21, 88);

    // Radius still at its reset value of zero: every point must be the origin.
    send_fracs(32'h0000_0000, 32'h0000_0000);
    send_fracs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fracs(32'h8000_0000, 32'h4000_0000);
    wait_drained();

    // Largest disk: full radial fraction walks every quadrant boundary and
    // drives the coordinates into saturation.
    load_radius(31'h7FFF_FFFF);
    foreach (corner_ang[i]) send_fracs(32'hFFFF_FFFF, corner_ang[i]);
    send_fracs(32'h0000_0000, 32'h1234_5678);
    send_fracs(32'h0000_0001, 32'h6000_0000);
    send_fracs(32'h4000_0000, 32'hA000_0000);
    wait_drained();

    // Unit disk.
    load_radius(31'h0001_0000);
    send_fracs(32'hFFFF_FFFF, 32'h2AAA_AAAA);
    send_fracs(32'h0000_0001, 32'hD555_5555);
    send_fracs(32'h8000_0000, 32'h5555_5555);
    wait_drained();

    // Random phases: first a slow receiver, then a slow sender, then full rate.
    for (p = 0; p < PHASES; p++) begin
      if (p < 3) set_idle(21, 88);
      else if (p < 6) set_idle(88, 21);
      else set_idle(0, 0);
      rad = (p == 3 || p == 5 || p == 7) ? RADIUS_W'($urandom) : phase_radius[p];
      load_radius(rad);
      if (p == 6) begin
        // Hold off the receiver for a long stretch while beats keep coming.
        stall_req <= 1'b1;
        @(posedge clk_i);
        stall_req <= 1'b0;
      end
      for (n = 0; n < BEATS_PER_PHASE; n++) send_fracs(rand_frac(), rand_frac());
      wait_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
